>>> design/ring_finger_table_router_defines.svh
// Assertion macros shared by the checker of the finger table router.
// Depends on nothing; included by the files that hold assertions.
// Each macro expands to one labeled concurrent assertion with a $error report.
`ifndef RING_FINGER_TABLE_ROUTER_DEFINES_SVH
`define RING_FINGER_TABLE_ROUTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFTR_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFTR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> design/rftr_pkg.sv
// Shared types and constants of the finger table router.
// Depends on nothing; used by the interfaces, all modules and the checker.
package rftr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_FINGER_COUNT = 32;
    localparam int DEF_ID_BITS      = 32;

    // Fixed widths of the beat fields.
    localparam int OP_W       = 2;
    localparam int FIDX_W     = 5;
    localparam int FIELD_ID_W = 32;
    localparam int KIND_W     = 2;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_FINGER = 2'd0,
        OP_NOTIFY       = 2'd1,
        OP_CLEAR_PRED   = 2'd2,
        OP_LOOKUP       = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        HOP_SELF   = 2'd0,
        HOP_SUCC   = 2'd1,
        HOP_FINGER = 2'd2,
        HOP_NONE   = 2'd3
    } hop_kind_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        op_t                   op;
        logic                  idx_ok;
        logic [FIDX_W-1:0]     finger_index;
        logic [FIELD_ID_W-1:0] node_id;
        logic [FIELD_ID_W-1:0] key;
    } item_t;

    // Fill status of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> design/rftr_if.sv
// Request and response channel interfaces of the finger table router.
// Depends on rftr_pkg for the field widths.
interface rftr_req_if
    import rftr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [FIDX_W-1:0]     finger_index;
    logic [FIELD_ID_W-1:0] node_id;
    logic [FIELD_ID_W-1:0] key;

    modport source (output valid, operation, finger_index, node_id, key, input ready);
    modport sink (input valid, operation, finger_index, node_id, key, output ready);
endinterface

interface rftr_rsp_if
    import rftr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FIELD_ID_W-1:0] next_hop_id;
    logic [FIDX_W-1:0]     next_hop_index;
    logic [KIND_W-1:0]     hop_kind;
    logic                  owned_locally;
    logic                  predecessor_taken;

    modport source (output valid, next_hop_id, next_hop_index, hop_kind, owned_locally,
                    predecessor_taken, input ready);
    modport sink (input valid, next_hop_id, next_hop_index, hop_kind, owned_locally,
                  predecessor_taken, output ready);
endinterface

>>> design/rftr_front.sv
// Front end: accepts request beats, decodes them and pushes them into the queue.
// Depends on rftr_pkg and rftr_req_if.
module rftr_front
    import rftr_pkg::*;
#(
    parameter int FINGER_COUNT = DEF_FINGER_COUNT
) (
    rftr_req_if.sink req,
    input  q_stat_t  q_stat,
    output logic     q_push,
    output item_t    q_item
);

    logic [7:0] fidx_wide;

    // A beat is taken whenever the queue has room.
    assign req.ready = !q_stat.full;
    assign q_push    = req.valid && !q_stat.full;

    // Decode the operation and flag finger writes that fall outside the table.
    always_comb
    begin
        fidx_wide           = {3'b000, req.finger_index};
        q_item.op           = op_t'(req.operation);
        q_item.idx_ok       = (fidx_wide < 8'(FINGER_COUNT));
        q_item.finger_index = req.finger_index;
        q_item.node_id      = req.node_id;
        q_item.key          = req.key;
    end

endmodule

>>> design/rftr_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on rftr_pkg.
module rftr_queue
    import rftr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   pop_item,
    output q_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/rftr_back.sv
// Back end: holds the ring state and finger memory, executes each operation
// and registers the response beat. Depends on rftr_pkg and rftr_rsp_if.
module rftr_back
    import rftr_pkg::*;
#(
    parameter int FINGER_COUNT = DEF_FINGER_COUNT,
    parameter int ID_BITS      = DEF_ID_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [FIELD_ID_W-1:0] cfg_wr_data,
    input  item_t                 q_item,
    input  q_stat_t               q_stat,
    output logic                  q_pop,
    rftr_rsp_if.source            rsp
);

    localparam int IDX_W = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FINGER_COUNT - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLASS = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } back_state_t;

    // Narrow or widen a field value to the identifier width.
    function automatic logic [ID_BITS-1:0] to_id(input logic [FIELD_ID_W-1:0] v);
        logic [63:0] w;
        w = {32'b0, v};
        return w[ID_BITS-1:0];
    endfunction

    function automatic logic [FIELD_ID_W-1:0] from_id(input logic [ID_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[FIELD_ID_W-1:0];
    endfunction

    // x strictly inside (lo, hi) on the ring; lo equal to hi is the ring without lo.
    function automatic logic ring_open(input logic [ID_BITS-1:0] lo,
                                       input logic [ID_BITS-1:0] x,
                                       input logic [ID_BITS-1:0] hi);
        if (lo < hi)
        begin
            return (lo < x) && (x < hi);
        end
        return (lo < x) || (x < hi);
    endfunction

    // x inside (lo, hi] on the ring; lo equal to hi is the whole ring.
    function automatic logic ring_half(input logic [ID_BITS-1:0] lo,
                                       input logic [ID_BITS-1:0] x,
                                       input logic [ID_BITS-1:0] hi);
        if (lo < hi)
        begin
            return (lo < x) && (x <= hi);
        end
        return (lo < x) || (x <= hi);
    endfunction

    // Finger identifiers live in a single-port memory.
    logic [ID_BITS-1:0]      finger_mem [FINGER_COUNT];

    back_state_t             state_reg, state_next;
    logic [ID_BITS-1:0]      self_reg, self_next;
    logic [ID_BITS-1:0]      pred_reg, pred_next;
    logic                    pred_valid_reg, pred_valid_next;
    logic [FINGER_COUNT-1:0] fvalid_reg, fvalid_next;
    logic [ID_BITS-1:0]      succ_reg, succ_next;
    logic [ID_BITS-1:0]      key_reg, key_next;
    logic [IDX_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                    scan_more_reg, scan_more_next;
    logic                    rd_live_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [ID_BITS-1:0]      rd_data_reg;
    logic [ID_BITS-1:0]      pend_id_reg, pend_id_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    hop_kind_t               pend_kind_reg, pend_kind_next;
    logic                    pend_owned_reg, pend_owned_next;
    logic                    pend_taken_reg, pend_taken_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ID_BITS-1:0]      out_id_reg, out_id_next;
    logic [IDX_W-1:0]        out_idx_reg, out_idx_next;
    hop_kind_t               out_kind_reg, out_kind_next;
    logic                    out_owned_reg, out_owned_next;
    logic                    out_taken_reg, out_taken_next;

    logic [7:0]              op_fidx_wide;
    logic [IDX_W-1:0]        op_idx;
    logic [ID_BITS-1:0]      op_nid;
    logic [ID_BITS-1:0]      succ_id;
    logic                    can_emit;
    logic                    scan_hit;
    logic                    scan_miss;
    logic                    mem_we;
    logic                    mem_re;
    logic [7:0]              out_idx_wide;

    // Operands of the beat at the head of the queue.
    always_comb
    begin
        op_fidx_wide = {3'b000, q_item.finger_index};
        op_idx       = op_fidx_wide[IDX_W-1:0];
        op_nid       = to_id(q_item.node_id);
    end

    assign succ_id   = fvalid_reg[0] ? succ_reg : self_reg;
    assign can_emit  = !out_valid_reg || rsp.ready;
    assign scan_hit  = rd_live_reg && fvalid_reg[rd_idx_reg]
                       && ring_open(self_reg, rd_data_reg, key_reg);
    assign scan_miss = rd_live_reg && !scan_hit && (rd_idx_reg == '0);
    assign mem_re    = (state_reg == ST_SCAN) && scan_more_reg && !scan_hit && !scan_miss;

    // Operation sequencer.
    always_comb
    begin
        state_next      = state_reg;
        self_next       = cfg_wr_en ? to_id(cfg_wr_data) : self_reg;
        pred_next       = pred_reg;
        pred_valid_next = pred_valid_reg;
        fvalid_next     = fvalid_reg;
        succ_next       = succ_reg;
        key_next        = key_reg;
        scan_idx_next   = scan_idx_reg;
        scan_more_next  = scan_more_reg;
        pend_id_next    = pend_id_reg;
        pend_idx_next   = pend_idx_reg;
        pend_kind_next  = pend_kind_reg;
        pend_owned_next = pend_owned_reg;
        pend_taken_next = pend_taken_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_id_next     = out_id_reg;
        out_idx_next    = out_idx_reg;
        out_kind_next   = out_kind_reg;
        out_owned_next  = out_owned_reg;
        out_taken_next  = out_taken_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop           = 1'b1;
                    pend_id_next    = '0;
                    pend_idx_next   = '0;
                    pend_kind_next  = HOP_SELF;
                    pend_owned_next = 1'b0;
                    pend_taken_next = 1'b0;
                    state_next      = ST_EMIT;
                    case (q_item.op)
                        OP_WRITE_FINGER:
                        begin
                            if (q_item.idx_ok)
                            begin
                                mem_we              = 1'b1;
                                fvalid_next[op_idx] = 1'b1;
                                if (op_idx == '0)
                                begin
                                    succ_next = op_nid;
                                end
                            end
                        end
                        OP_NOTIFY:
                        begin
                            if (!pred_valid_reg || ring_open(pred_reg, op_nid, self_reg))
                            begin
                                pred_next       = op_nid;
                                pred_valid_next = 1'b1;
                                pend_taken_next = 1'b1;
                            end
                        end
                        OP_CLEAR_PRED:
                        begin
                            pred_next       = '0;
                            pred_valid_next = 1'b0;
                        end
                        OP_LOOKUP:
                        begin
                            key_next   = to_id(q_item.key);
                            state_next = ST_CLASS;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            // Ownership and the self and successor cases.
            ST_CLASS:
            begin
                if (!pred_valid_reg)
                begin
                    pend_owned_next = 1'b1;
                end
                else if (pred_reg == self_reg)
                begin
                    pend_owned_next = (key_reg == self_reg);
                end
                else
                begin
                    pend_owned_next = ring_half(pred_reg, key_reg, self_reg);
                end

                if (key_reg == self_reg)
                begin
                    pend_id_next   = self_reg;
                    pend_kind_next = HOP_SELF;
                    state_next     = ST_EMIT;
                end
                else if (ring_half(self_reg, key_reg, succ_id))
                begin
                    pend_id_next   = succ_id;
                    pend_kind_next = HOP_SUCC;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    scan_idx_next  = LAST_IDX;
                    scan_more_next = 1'b1;
                    state_next     = ST_SCAN;
                end
            end

            // Read one finger a cycle from the top down; check the previous read.
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    pend_id_next   = rd_data_reg;
                    pend_idx_next  = rd_idx_reg;
                    pend_kind_next = HOP_FINGER;
                    scan_more_next = 1'b0;
                    state_next     = ST_EMIT;
                end
                else if (scan_miss)
                begin
                    pend_id_next   = self_reg;
                    pend_kind_next = HOP_NONE;
                    scan_more_next = 1'b0;
                    state_next     = ST_EMIT;
                end
                else if (mem_re)
                begin
                    scan_more_next = (scan_idx_reg != '0);
                    scan_idx_next  = scan_idx_reg - 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = pend_id_reg;
                    out_idx_next   = pend_idx_reg;
                    out_kind_next  = pend_kind_reg;
                    out_owned_next = pend_owned_reg;
                    out_taken_next = pend_taken_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and ring state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            self_reg       <= '0;
            pred_reg       <= '0;
            pred_valid_reg <= 1'b0;
            fvalid_reg     <= '0;
            scan_idx_reg   <= '0;
            scan_more_reg  <= 1'b0;
            rd_live_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            self_reg       <= self_next;
            pred_reg       <= pred_next;
            pred_valid_reg <= pred_valid_next;
            fvalid_reg     <= fvalid_next;
            scan_idx_reg   <= scan_idx_next;
            scan_more_reg  <= scan_more_next;
            rd_live_reg    <= mem_re;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        succ_reg       <= succ_next;
        key_reg        <= key_next;
        pend_id_reg    <= pend_id_next;
        pend_idx_reg   <= pend_idx_next;
        pend_kind_reg  <= pend_kind_next;
        pend_owned_reg <= pend_owned_next;
        pend_taken_reg <= pend_taken_next;
        out_id_reg     <= out_id_next;
        out_idx_reg    <= out_idx_next;
        out_kind_reg   <= out_kind_next;
        out_owned_reg  <= out_owned_next;
        out_taken_reg  <= out_taken_next;
    end

    // Finger memory write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            finger_mem[op_idx] <= op_nid;
        end
    end

    // Finger memory read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= finger_mem[scan_idx_reg];
            rd_idx_reg  <= scan_idx_reg;
        end
    end

    // Response beat.
    always_comb
    begin
        out_idx_wide          = 8'(out_idx_reg);
        rsp.valid             = out_valid_reg;
        rsp.next_hop_id       = from_id(out_id_reg);
        rsp.next_hop_index    = out_idx_wide[FIDX_W-1:0];
        rsp.hop_kind          = out_kind_reg;
        rsp.owned_locally     = out_owned_reg;
        rsp.predecessor_taken = out_taken_reg;
    end

endmodule

>>> design/ring_finger_table_router.sv
// Finger table router of one node on a consistent-hash ring. Each request beat
// carries one operation (write finger, notify predecessor, clear predecessor,
// look up key) and yields exactly one response beat, in order. A front end
// takes beats into a two-entry queue whenever it has room, so requests keep
// arriving while the back end works or a response waits. In the back end a
// finger write, notify or clear goes from idle to emit; a lookup answered by
// self or the successor goes through idle, classify and emit; a finger scan
// reads the single-port finger memory one entry per cycle from the highest
// index down. self_id is written through cfg_wr_en / cfg_wr_data; the user
// must do so only while the block is idle, as the block does not enforce it.
module ring_finger_table_router
    import rftr_pkg::*;
#(
    parameter int FINGER_COUNT = DEF_FINGER_COUNT,
    parameter int ID_BITS      = DEF_ID_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [FIELD_ID_W-1:0] cfg_wr_data,
    rftr_req_if.sink              req,
    rftr_rsp_if.source            rsp
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    item_t   push_item;
    item_t   head_item;

    rftr_front #(
        .FINGER_COUNT(FINGER_COUNT)
    ) u_front (
        .req    (req),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_item (push_item)
    );

    rftr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (head_item),
        .stat      (q_stat)
    );

    rftr_back #(
        .FINGER_COUNT(FINGER_COUNT),
        .ID_BITS     (ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_item      (head_item),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .rsp         (rsp)
    );

endmodule

>>> design/rftr_checker.sv
// Port-level checker of the finger table router and its bind statement.
// Depends on rftr_pkg and ring_finger_table_router_defines.svh.
`include "ring_finger_table_router_defines.svh"

module rftr_checker
    import rftr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [FIELD_ID_W-1:0] rsp_id,
    input logic [FIDX_W-1:0]     rsp_index,
    input logic [KIND_W-1:0]     rsp_kind,
    input logic                  rsp_owned,
    input logic                  rsp_taken
);

    // A stalled response beat stays and holds its payload.
    `RFTR_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_id, rsp_index, rsp_kind, rsp_owned, rsp_taken}), "response beat changed while stalled")

    // A finger index is reported only when forwarding via a finger.
    `RFTR_ASSERT_NOW(a_index_kind, clk, rst_n, rsp_valid && (rsp_kind != HOP_FINGER), rsp_index == '0, "finger index set on a non-finger hop")

    // A taken predecessor comes from a notify, whose lookup fields are zero.
    `RFTR_ASSERT_NOW(a_taken_clean, clk, rst_n, rsp_valid && rsp_taken, (rsp_id == '0) && (rsp_kind == HOP_SELF) && !rsp_owned, "notify beat carries lookup fields")

endmodule

bind ring_finger_table_router rftr_checker u_rftr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_id    (rsp.next_hop_id),
    .rsp_index (rsp.next_hop_index),
    .rsp_kind  (rsp.hop_kind),
    .rsp_owned (rsp.owned_locally),
    .rsp_taken (rsp.predecessor_taken)
);

>>> bench/ring_finger_table_router_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for ring_finger_table_router: random and directed request beats
// are checked, response by response, against a finger table and predecessor predictor.
// Depends on rftr_pkg, the rftr_req_if / rftr_rsp_if interfaces and the router RTL.
module ring_finger_table_router_tb;
    import rftr_pkg::*;

    localparam int FINGERS       = DEF_FINGER_COUNT;
    localparam int IDLE_PCT      = 35;
    localparam int STALL_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_BEATS   = 200;
    localparam logic [FIELD_ID_W-1:0] D_SELF = 32'h1000_0000;

    typedef struct {
        op_t                   op;
        logic [FIDX_W-1:0]     finger_index;
        logic [FIELD_ID_W-1:0] node_id;
        logic [FIELD_ID_W-1:0] key;
    } route_req_t;

    typedef struct {
        logic [FIELD_ID_W-1:0] hop_id;
        logic [FIDX_W-1:0]     hop_index;
        hop_kind_t             kind;
        logic                  owned;
        logic                  taken;
    } route_rsp_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en = 1'b0;
    logic [FIELD_ID_W-1:0] cfg_wr_data = '0;

    rftr_req_if req_ch ();
    rftr_rsp_if rsp_ch ();

    ring_finger_table_router dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Predicted node state.
    logic [FIELD_ID_W-1:0] node_self = '0;
    logic [FIELD_ID_W-1:0] finger_id [FINGERS];
    logic                  finger_ok [FINGERS] = '{default: 1'b0};
    logic [FIELD_ID_W-1:0] pred_id = '0;
    logic                  pred_ok = 1'b0;

    // What the stimulus side believes it has written, used to aim keys.
    logic [FIELD_ID_W-1:0] plan_id [FINGERS] = '{default: '0};
    logic                  plan_ok [FINGERS] = '{default: 1'b0};
    logic [FIELD_ID_W-1:0] gen_pred = '0;

    route_req_t pending_q [$];
    route_rsp_t expected_q [$];

    int   n_req_acc = 0;
    int   n_rsp = 0;
    int   n_taken = 0;
    int   n_self_writes = 0;
    int   err_count = 0;
    int   kind_seen [4] = '{default: 0};
    logic hold_want = 1'b0;
    logic hold_spent;
    int   hold_left;
    logic calm;

    // A stretch of beats in which neither side idles.
    assign calm = (n_req_acc >= 800) && (n_req_acc < 1000);

    always #10 clk = ~clk;

    // x strictly inside (lo, hi) on the ring; lo == hi covers all but lo.
    function automatic bit ring_open(logic [FIELD_ID_W-1:0] lo, logic [FIELD_ID_W-1:0] x,
                                     logic [FIELD_ID_W-1:0] hi);
        if (lo < hi)
            return (lo < x) && (x < hi);
        return (lo < x) || (x < hi);
    endfunction

    // x inside (lo, hi] on the ring; lo == hi covers the whole ring.
    function automatic bit ring_half(logic [FIELD_ID_W-1:0] lo, logic [FIELD_ID_W-1:0] x,
                                     logic [FIELD_ID_W-1:0] hi);
        if (lo < hi)
            return (lo < x) && (x <= hi);
        return (lo < x) || (x <= hi);
    endfunction

    // Applies one accepted request to the predicted state and returns its response.
    function automatic route_rsp_t route_predict(route_req_t rq);
        route_rsp_t            r;
        logic [FIELD_ID_W-1:0] succ;
        r.hop_id    = '0;
        r.hop_index = '0;
        r.kind      = HOP_SELF;
        r.owned     = 1'b0;
        r.taken     = 1'b0;
        case (rq.op)
            OP_WRITE_FINGER:
            begin
                finger_id[rq.finger_index] = rq.node_id;
                finger_ok[rq.finger_index] = 1'b1;
            end
            OP_NOTIFY:
            begin
                if (!pred_ok || ring_open(pred_id, rq.node_id, node_self))
                begin
                    pred_id = rq.node_id;
                    pred_ok = 1'b1;
                    r.taken = 1'b1;
                    n_taken++;
                end
            end
            OP_CLEAR_PRED:
            begin
                pred_id = '0;
                pred_ok = 1'b0;
            end
            default:
            begin
                succ = finger_ok[0] ? finger_id[0] : node_self;
                if (!pred_ok)
                    r.owned = 1'b1;
                else if (pred_id == node_self)
                    r.owned = (rq.key == node_self);
                else
                    r.owned = ring_half(pred_id, rq.key, node_self);

                if (rq.key == node_self)
                begin
                    r.hop_id = node_self;
                    r.kind   = HOP_SELF;
                end
                else if (ring_half(node_self, rq.key, succ))
                begin
                    r.hop_id = succ;
                    r.kind   = HOP_SUCC;
                end
                else
                begin
                    // Highest valid finger that lies between self and the key.
                    r.hop_id = node_self;
                    r.kind   = HOP_NONE;
                    for (int i = FINGERS - 1; i >= 0; i--)
                    begin
                        if (finger_ok[i] && ring_open(node_self, finger_id[i], rq.key))
                        begin
                            r.hop_id    = finger_id[i];
                            r.hop_index = FIDX_W'(i);
                            r.kind      = HOP_FINGER;
                            break;
                        end
                    end
                end
                kind_seen[r.kind]++;
            end
        endcase
        return r;
    endfunction

    // Request driver: records the prediction of each accepted beat, then offers the next.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        route_req_t seen;
        route_req_t nxt;
        if (!rst_n)
        begin
            req_ch.valid        <= 1'b0;
            req_ch.operation    <= '0;
            req_ch.finger_index <= '0;
            req_ch.node_id      <= '0;
            req_ch.key          <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen.op           = op_t'(req_ch.operation);
                seen.finger_index = req_ch.finger_index;
                seen.node_id      = req_ch.node_id;
                seen.key          = req_ch.key;
                expected_q.push_back(route_predict(seen));
                n_req_acc <= n_req_acc + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_q.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.operation    <= nxt.op;
                    req_ch.finger_index <= nxt.finger_index;
                    req_ch.node_id      <= nxt.node_id;
                    req_ch.key          <= nxt.key;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, started once the stimulus asks for it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_spent <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_want && !hold_spent)
        begin
            hold_left  <= STALL_CYCLES;
            hold_spent <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [FIELD_ID_W-1:0] want_v,
                               logic [FIELD_ID_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            err_count++;
        end
    endtask

    // Response monitor: each accepted beat is compared with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        route_rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_rsp++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected response beat, expected none, actual hop %h kind %0d",
                             $time, rsp_ch.next_hop_id, rsp_ch.hop_kind);
                    err_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("next_hop_id", want.hop_id, rsp_ch.next_hop_id);
                    check_field("next_hop_index", FIELD_ID_W'(want.hop_index),
                                FIELD_ID_W'(rsp_ch.next_hop_index));
                    check_field("hop_kind", FIELD_ID_W'(want.kind),
                                FIELD_ID_W'(rsp_ch.hop_kind));
                    check_field("owned_locally", FIELD_ID_W'(want.owned),
                                FIELD_ID_W'(rsp_ch.owned_locally));
                    check_field("predecessor_taken", FIELD_ID_W'(want.taken),
                                FIELD_ID_W'(rsp_ch.predecessor_taken));
                end
            end
            rsp_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic void push_beat(op_t op, logic [FIDX_W-1:0] fidx,
                                      logic [FIELD_ID_W-1:0] nid, logic [FIELD_ID_W-1:0] key);
        route_req_t rq;
        rq.op           = op;
        rq.finger_index = fidx;
        rq.node_id      = nid;
        rq.key          = key;
        pending_q.push_back(rq);
        if (op == OP_WRITE_FINGER)
        begin
            plan_id[fidx] = nid;
            plan_ok[fidx] = 1'b1;
        end
        else if (op == OP_NOTIFY)
        begin
            gen_pred = nid;
        end
    endfunction

    // Chord-like finger i: somewhere in [self + 2^i, self + 2^(i+1)), now and then anywhere.
    function automatic logic [FIELD_ID_W-1:0] finger_for(int i);
        logic [FIELD_ID_W-1:0] span;
        span = 32'd1 << i;
        if ($urandom_range(3) == 0)
            return $urandom();
        return node_self + span + ($urandom() & (span - 32'd1));
    endfunction

    // An identifier near one of the ring's landmarks, or anywhere.
    function automatic logic [FIELD_ID_W-1:0] pick_id();
        logic [FIDX_W-1:0]     j;
        logic [FIELD_ID_W-1:0] base;
        j = FIDX_W'($urandom_range(FINGERS - 1));
        case ($urandom_range(5))
            0: base = node_self;
            1: base = plan_ok[j] ? plan_id[j] : node_self + (32'd1 << j);
            2: base = plan_ok[0] ? plan_id[0] : node_self;
            3: base = gen_pred;
            4: base = node_self + (32'd1 << j);
            default: return $urandom();
        endcase
        return base + 32'($urandom_range(2)) - 32'd1;
    endfunction

    task automatic set_self(logic [FIELD_ID_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        node_self = v;
        n_self_writes++;
        @(negedge clk);
    endtask

    // Waits until every queued beat went in and every response came back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0);
    endtask

    initial
    begin
        logic [FIELD_ID_W-1:0] selves [PHASES];
        int                    roll;
        int                    idx;

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_self(D_SELF);

        // Empty table: key equal to self, then the lonely successor at both ends.
        push_beat(OP_LOOKUP, 0, 0, D_SELF);
        push_beat(OP_LOOKUP, 0, 0, 32'h0000_0000);
        push_beat(OP_LOOKUP, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Predecessor handling: clear with none held, take, refuse, take a closer one.
        push_beat(OP_CLEAR_PRED, 0, 0, 0);
        push_beat(OP_NOTIFY, 0, 32'h0800_0000, 0);
        push_beat(OP_NOTIFY, 0, 32'h0400_0000, 0);
        push_beat(OP_NOTIFY, 0, 32'h0C00_0000, 0);
        push_beat(OP_LOOKUP, 0, 0, 32'h0C00_0000);
        push_beat(OP_LOOKUP, 0, 0, 32'h0C00_0001);
        // A predecessor equal to self owns only the key self.
        push_beat(OP_CLEAR_PRED, 0, 0, 0);
        push_beat(OP_NOTIFY, 0, D_SELF, 0);
        push_beat(OP_LOOKUP, 0, 0, D_SELF);
        push_beat(OP_LOOKUP, 0, 0, D_SELF + 32'd1);
        push_beat(OP_NOTIFY, 0, 32'h0000_0000, 0);
        // Sparse table with both end indexes, then successor and finger hops.
        push_beat(OP_WRITE_FINGER, 0, 32'h2000_0000, 0);
        push_beat(OP_WRITE_FINGER, 31, 32'hF000_0000, 0);
        push_beat(OP_WRITE_FINGER, 5, 32'h8000_0000, 0);
        push_beat(OP_LOOKUP, 0, 0, 32'h1800_0000);
        push_beat(OP_LOOKUP, 0, 0, 32'h2000_0000);
        push_beat(OP_LOOKUP, 0, 0, 32'h9000_0000);
        push_beat(OP_LOOKUP, 0, 0, 32'hFFFF_FFFF);
        push_beat(OP_WRITE_FINGER, 7, 32'hFFFF_FFFF, 0);
        push_beat(OP_WRITE_FINGER, 6, 32'h0000_0000, 0);
        push_beat(OP_LOOKUP, 0, 0, 32'h0000_0000);
        push_beat(OP_LOOKUP, 0, 0, 32'h0FFF_FFFF);

        selves[0] = 32'h0000_0000;
        selves[1] = 32'hFFFF_FFFF;
        selves[2] = 32'h8000_0000;
        selves[3] = $urandom();
        selves[4] = 32'h0000_0001;
        selves[5] = $urandom();

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            set_self(selves[p]);

            // Rebuild most of the table around the new self.
            for (int i = 0; i < FINGERS; i++)
                if ($urandom_range(3) != 0)
                    push_beat(OP_WRITE_FINGER, FIDX_W'(i), finger_for(i), $urandom());

            // In the second phase the receiver stops while this batch is offered.
            if (p == 1)
                hold_want = 1'b1;

            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                // Halfway through, the sender waits for every response.
                if (k == PHASE_BEATS / 2)
                    wait_idle();
                roll = $urandom_range(99);
                if (roll < 55)
                begin
                    push_beat(OP_LOOKUP, FIDX_W'($urandom()), $urandom(), pick_id());
                end
                else if (roll < 70)
                begin
                    idx = $urandom_range(FINGERS - 1);
                    push_beat(OP_WRITE_FINGER, FIDX_W'(idx), finger_for(idx), $urandom());
                end
                else if (roll < 88)
                begin
                    push_beat(OP_NOTIFY, FIDX_W'($urandom()), pick_id(), $urandom());
                end
                else if (roll < 94)
                begin
                    push_beat(OP_CLEAR_PRED, FIDX_W'($urandom()), $urandom(), $urandom());
                end
                else
                begin
                    push_beat(op_t'($urandom_range(3)), FIDX_W'($urandom()), $urandom(),
                              $urandom());
                end
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d request and %0d response beats under %0d self_id values;",
                 n_req_acc, n_rsp, n_self_writes);
        $display("lookups self/succ/finger/none %0d/%0d/%0d/%0d, notifies taken %0d.",
                 kind_seen[HOP_SELF], kind_seen[HOP_SUCC], kind_seen[HOP_FINGER],
                 kind_seen[HOP_NONE], n_taken);
        if (err_count == 0)
            $display("ring_finger_table_router_tb: done, clean");
        else
            $display("ring_finger_table_router_tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #12_000_000;
        $display("Timeout with %0d responses still outstanding.", expected_q.size());
        $display("ring_finger_table_router_tb: done, errors");
        $finish;
    end

endmodule
